@@ hw/rtl/cpsr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpsr_pkg
// Types, codes and button maps shared by the controller port serial reader.
// ----------------------------------------------------------------------------
`default_nettype none

package cpsr_pkg;

  localparam int unsigned DevW   = 3;
  localparam int unsigned ExpW   = 2;
  localparam int unsigned CntW   = 5;
  localparam int unsigned BtnW   = 16;
  localparam int unsigned DataW  = 5;
  localparam int unsigned AddrW  = 4;
  localparam int unsigned ApbW   = 32;

  localparam logic [DevW-1:0] DEV_NONE      = 3'd0;
  localparam logic [DevW-1:0] DEV_JOYPAD    = 3'd1;
  localparam logic [DevW-1:0] DEV_FOURSCORE = 3'd2;
  localparam logic [DevW-1:0] DEV_LIGHTGUN  = 3'd3;
  localparam logic [DevW-1:0] DEV_MATPAD    = 3'd4;

  localparam logic [ExpW-1:0] EXP_NONE       = 2'd0;
  localparam logic [ExpW-1:0] EXP_FOURPLAYER = 2'd1;
  localparam logic [ExpW-1:0] EXP_BEAMGUN    = 2'd2;

  localparam logic REQ_LATCH = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  localparam logic [1:0] REG_PORT0     = 2'd0;
  localparam logic [1:0] REG_PORT1     = 2'd1;
  localparam logic [1:0] REG_EXPANSION = 2'd2;

  localparam logic [CntW-1:0] CNT_MAX    = 5'd31;
  localparam logic [CntW-1:0] JOY_BITS   = 5'd8;
  localparam logic [CntW-1:0] FOUR_BITS  = 5'd16;
  localparam logic [CntW-1:0] SIG_BASE   = 5'd19;
  localparam logic [CntW-1:0] FOUR_ONES  = 5'd24;
  localparam logic [CntW-1:0] MAT_B_BITS = 5'd4;

  typedef struct packed {
    logic [DevW-1:0] port0_device;
    logic [DevW-1:0] port1_device;
    logic [ExpW-1:0] expansion_device;
  } cfg_t;

  typedef struct packed {
    logic            req_type;
    logic            latch_value;
    logic            port;
    logic [BtnW-1:0] port_buttons;
    logic            port_trigger;
    logic [BtnW-1:0] expansion_buttons;
    logic            expansion_trigger;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             advance;
  } read_res_t;

  function automatic logic [3:0] mat_map_a(input logic [2:0] idx);
    logic [3:0] m;
    case (idx)
      3'd0:    m = 4'd1;
      3'd1:    m = 4'd0;
      3'd2:    m = 4'd4;
      3'd3:    m = 4'd8;
      3'd4:    m = 4'd5;
      3'd5:    m = 4'd9;
      3'd6:    m = 4'd10;
      default: m = 4'd6;
    endcase
    return m;
  endfunction

  function automatic logic [3:0] mat_map_b(input logic [1:0] idx);
    logic [3:0] m;
    case (idx)
      2'd0:    m = 4'd3;
      2'd1:    m = 4'd2;
      2'd2:    m = 4'd11;
      default: m = 4'd7;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cpsr_ifs.sv @@
// ----------------------------------------------------------------------------
// cpsr_ifs
// Valid/ready channels for bus requests and read results.
// ----------------------------------------------------------------------------
`default_nettype none

interface cpsr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        latch_value;
  logic        port;
  logic [15:0] port_buttons;
  logic        port_trigger;
  logic [15:0] expansion_buttons;
  logic        expansion_trigger;

  modport source (
    output valid, req_type, latch_value, port, port_buttons, port_trigger,
           expansion_buttons, expansion_trigger,
    input  ready
  );
  modport sink (
    input  valid, req_type, latch_value, port, port_buttons, port_trigger,
           expansion_buttons, expansion_trigger,
    output ready
  );
endinterface

interface cpsr_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/cpsr_cfg.sv @@
// ----------------------------------------------------------------------------
// cpsr_cfg
// APB register file holding the device types of both ports and the expansion.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsr_cfg import cpsr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [ApbW-1:0]  pwdata,
  output logic      [ApbW-1:0]  prdata,
  output logic                  pready,
  output cfg_t                  cfg_o
);

  cfg_t       cfg_q, cfg_d;
  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_PORT0:     cfg_d.port0_device     = pwdata[DevW-1:0];
        REG_PORT1:     cfg_d.port1_device     = pwdata[DevW-1:0];
        REG_EXPANSION: cfg_d.expansion_device = pwdata[ExpW-1:0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_PORT0:     prdata[DevW-1:0] = cfg_q.port0_device;
      REG_PORT1:     prdata[DevW-1:0] = cfg_q.port1_device;
      REG_EXPANSION: prdata[ExpW-1:0] = cfg_q.expansion_device;
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.port0_device     <= DEV_JOYPAD;
      cfg_q.port1_device     <= DEV_JOYPAD;
      cfg_q.expansion_device <= EXP_FOURPLAYER;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/cpsr_read_logic.sv @@
// ----------------------------------------------------------------------------
// cpsr_read_logic
// Builds the five-bit port read value from the attached devices and counter.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsr_read_logic import cpsr_pkg::*; (
  input  wire req_t             req_i,
  input  wire cfg_t             cfg_i,
  input  wire logic  [CntW-1:0] count_i,
  input  wire logic             strobe_i,
  output read_res_t             res_o
);

  logic [DevW-1:0]  dev;
  logic [DataW-1:0] r;
  logic [CntW-1:0]  sig_pos;
  logic [3:0]       xidx;

  assign dev     = req_i.port ? cfg_i.port1_device : cfg_i.port0_device;
  assign sig_pos = SIG_BASE - {{(CntW-1){1'b0}}, req_i.port};
  assign xidx    = {req_i.port, count_i[2:0]};

  always_comb begin
    r = '0;
    case (dev)
      DEV_JOYPAD: begin
        r[0] = (count_i >= JOY_BITS) ? 1'b1 : req_i.port_buttons[count_i[3:0]];
      end
      DEV_FOURSCORE: begin
        if (count_i >= FOUR_BITS) begin
          r[0] = (count_i >= FOUR_ONES) || (count_i == sig_pos);
        end else begin
          r[0] = req_i.port_buttons[count_i[3:0]];
        end
      end
      DEV_LIGHTGUN: begin
        r[3] = 1'b1;
        r[4] = req_i.port_trigger;
      end
      DEV_MATPAD: begin
        r[3] = (count_i >= JOY_BITS) ? 1'b1
             : req_i.port_buttons[mat_map_a(count_i[2:0])];
        r[4] = (count_i >= MAT_B_BITS) ? 1'b1
             : req_i.port_buttons[mat_map_b(count_i[1:0])];
      end
      default: r = '0;
    endcase

    if (dev != DEV_NONE) begin
      case (cfg_i.expansion_device)
        EXP_FOURPLAYER: begin
          r[1] = (count_i >= JOY_BITS) ? 1'b1 : req_i.expansion_buttons[xidx];
        end
        EXP_BEAMGUN: begin
          if (req_i.port) begin
            r[3] = 1'b1;
            r[4] = r[4] | req_i.expansion_trigger;
          end
        end
        default: ;
      endcase
    end
  end

  assign res_o.read_data = r;
  assign res_o.advance   = (dev != DEV_NONE) && !strobe_i && (count_i != CNT_MAX);

endmodule

`default_nettype wire

@@ hw/rtl/cpsr_engine.sv @@
// ----------------------------------------------------------------------------
// cpsr_engine
// Request register, strobe and counter state, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpsr_engine import cpsr_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  cpsr_req_if.sink    req_i,
  cpsr_rsp_if.source  rsp_o
);

  req_t             s1_q;
  logic             s1_valid_q, s1_valid_d;
  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] out_data_q;
  logic             strobe_q, strobe_d;
  logic [CntW-1:0]  cnt0_q, cnt0_d, cnt1_q, cnt1_d;
  logic [CntW-1:0]  cur_cnt;
  logic             out_free, s1_go, in_take;
  read_res_t        res;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign s1_go    = s1_valid_q && ((s1_q.req_type == REQ_LATCH) || out_free);
  assign req_i.ready = !s1_valid_q || s1_go;
  assign in_take  = req_i.valid && req_i.ready;
  assign cur_cnt  = s1_q.port ? cnt1_q : cnt0_q;

  cpsr_read_logic u_read_logic (
    .req_i    (s1_q),
    .cfg_i    (cfg_i),
    .count_i  (cur_cnt),
    .strobe_i (strobe_q),
    .res_o    (res)
  );

  always_comb begin
    s1_valid_d  = in_take ? 1'b1 : (s1_go ? 1'b0 : s1_valid_q);
    out_valid_d = out_valid_q && !rsp_o.ready;
    strobe_d    = strobe_q;
    cnt0_d      = cnt0_q;
    cnt1_d      = cnt1_q;
    if (s1_go) begin
      if (s1_q.req_type == REQ_LATCH) begin
        strobe_d = s1_q.latch_value;
        if (s1_q.latch_value) begin
          cnt0_d = '0;
          cnt1_d = '0;
        end
      end else begin
        out_valid_d = 1'b1;
        if (res.advance) begin
          if (s1_q.port) begin
            cnt1_d = cnt1_q + 1'b1;
          end else begin
            cnt0_d = cnt0_q + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      strobe_q    <= 1'b0;
      cnt0_q      <= '0;
      cnt1_q      <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      strobe_q    <= strobe_d;
      cnt0_q      <= cnt0_d;
      cnt1_q      <= cnt1_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.req_type          <= req_i.req_type;
      s1_q.latch_value       <= req_i.latch_value;
      s1_q.port              <= req_i.port;
      s1_q.port_buttons      <= req_i.port_buttons;
      s1_q.port_trigger      <= req_i.port_trigger;
      s1_q.expansion_buttons <= req_i.expansion_buttons;
      s1_q.expansion_trigger <= req_i.expansion_trigger;
    end
    if (s1_go && (s1_q.req_type == REQ_READ)) begin
      out_data_q <= res.read_data;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_data_q;

endmodule

`default_nettype wire

@@ hw/rtl/controller_port_serial_reader_unit.sv @@
// ----------------------------------------------------------------------------
// controller_port_serial_reader_unit
// Two controller ports and an expansion port read out serially by the host.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle, latch writes and port reads
// alike, as long as the result side does not hold back a read. Each read's
// five-bit value passes the request register, then the result register.
// Latch writes produce no result. The device types are set over the APB port
// and must only change while no request is in flight.
`default_nettype none

module controller_port_serial_reader_unit import cpsr_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [ApbW-1:0]  pwdata,
  output logic      [ApbW-1:0]  prdata,
  output logic                  pready,
  cpsr_req_if.sink              req_i,
  cpsr_rsp_if.source            rsp_o
);

  cfg_t cfg;

  cpsr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  cpsr_engine u_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg),
    .req_i  (req_i),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

@@ bench/port_read_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// port_read_monitor
// Watches the request and result channels and the APB port of the controller
// port serial reader. It keeps its own copy of the device settings, the strobe
// and both read counters, works out the value of every port read, and compares
// each returned result with the oldest value still due.
// ----------------------------------------------------------------------------

module port_read_monitor import cpsr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  cpsr_req_if              req,
  cpsr_rsp_if              rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic             pready,
  input  logic [AddrW-1:0] paddr,
  input  logic [ApbW-1:0]  pwdata,
  output int               errors_o,
  output int               pending_o
);

  // Button index for each count of the mat pad's two serial streams.
  localparam logic [31:0] MAT_A_MAP = {4'd6, 4'd10, 4'd9, 4'd5, 4'd8, 4'd4, 4'd0, 4'd1};
  localparam logic [15:0] MAT_B_MAP = {4'd7, 4'd11, 4'd2, 4'd3};

  cfg_t             dev_cfg;
  logic             strobe;
  logic [CntW-1:0]  read_cnt [2];
  logic [DataW-1:0] reads_due [$];
  logic [DataW-1:0] due_val;
  logic [CntW-1:0]  cnt_now;
  logic [DevW-1:0]  dev_now;
  req_t             rq;
  int               errors;

  function automatic logic [DataW-1:0] serial_read_value(input cfg_t c, input logic [CntW-1:0] n,
                                                         input req_t r);
    logic [DataW-1:0] v;
    logic [DevW-1:0]  dev;
    v = '0;
    dev = r.port ? c.port1_device : c.port0_device;
    if (dev == DEV_NONE) return '0;
    case (dev)
      DEV_JOYPAD: begin
        v[0] = (n >= JOY_BITS) ? 1'b1 : r.port_buttons[n[3:0]];
      end
      DEV_FOURSCORE: begin
        if (n >= FOUR_BITS) v[0] = (n >= FOUR_ONES) || (n == SIG_BASE - {4'b0, r.port});
        else v[0] = r.port_buttons[n[3:0]];
      end
      DEV_LIGHTGUN: begin
        v[3] = 1'b1;
        v[4] = r.port_trigger;
      end
      DEV_MATPAD: begin
        v[3] = (n >= JOY_BITS) ? 1'b1 : r.port_buttons[MAT_A_MAP[4*n[2:0] +: 4]];
        v[4] = (n >= MAT_B_BITS) ? 1'b1 : r.port_buttons[MAT_B_MAP[4*n[1:0] +: 4]];
      end
      default: ;
    endcase
    if (c.expansion_device == EXP_FOURPLAYER) begin
      v[1] = (n >= JOY_BITS) ? 1'b1 : r.expansion_buttons[{r.port, n[2:0]}];
    end else if (c.expansion_device == EXP_BEAMGUN && r.port) begin
      v[3] = 1'b1;
      v[4] = v[4] | r.expansion_trigger;
    end
    return v;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_cfg.port0_device     = DEV_JOYPAD;
      dev_cfg.port1_device     = DEV_JOYPAD;
      dev_cfg.expansion_device = EXP_FOURPLAYER;
      strobe      = 1'b0;
      read_cnt[0] = '0;
      read_cnt[1] = '0;
      reads_due.delete();
      errors      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[AddrW-1:2])
          REG_PORT0:     dev_cfg.port0_device     = pwdata[DevW-1:0];
          REG_PORT1:     dev_cfg.port1_device     = pwdata[DevW-1:0];
          REG_EXPANSION: dev_cfg.expansion_device = pwdata[ExpW-1:0];
          default: ;
        endcase
      end
      if (rsp.valid && rsp.ready) begin
        if (reads_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected read result: expected none, actual %0d", $time,
                   rsp.read_data);
        end else begin
          due_val = reads_due.pop_front();
          if (rsp.read_data !== due_val) begin
            errors++;
            $display("%0t: read_data mismatch: expected %0d, actual %0d", $time, due_val,
                     rsp.read_data);
          end
        end
      end
      if (req.valid && req.ready) begin
        if (req.req_type == REQ_LATCH) begin
          strobe = req.latch_value;
          if (strobe) begin
            read_cnt[0] = '0;
            read_cnt[1] = '0;
          end
        end else begin
          rq.req_type          = req.req_type;
          rq.latch_value       = req.latch_value;
          rq.port              = req.port;
          rq.port_buttons      = req.port_buttons;
          rq.port_trigger      = req.port_trigger;
          rq.expansion_buttons = req.expansion_buttons;
          rq.expansion_trigger = req.expansion_trigger;
          cnt_now = read_cnt[rq.port];
          dev_now = rq.port ? dev_cfg.port1_device : dev_cfg.port0_device;
          reads_due.push_back(serial_read_value(dev_cfg, cnt_now, rq));
          if (dev_now != DEV_NONE && !strobe && cnt_now != CNT_MAX) begin
            read_cnt[rq.port] = cnt_now + 1'b1;
          end
        end
      end
    end
    errors_o  = errors;
    pending_o = reads_due.size();
  end

endmodule

@@ bench/controller_port_serial_reader_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// controller_port_serial_reader_unit_tb
// Drives latch and read requests into the controller port serial reader under
// a range of device settings written over APB. A short directed sequence comes
// first, then latch/read sequences with random button data mixed with random
// requests. Requests arrive in bursts and the result side stalls on its own
// pattern; a separate monitor predicts and checks every read.
// ----------------------------------------------------------------------------

module controller_port_serial_reader_unit_tb;
  import cpsr_pkg::*;

  localparam int              NUM_PHASES      = 12;
  localparam int              ITEMS_PER_PHASE = 120;
  localparam int              SETTLE_CYCLES   = 6;
  localparam int              WATCHDOG_LIMIT  = 2000;
  localparam logic [DevW-1:0] DEV_UNKNOWN     = 3'd7;
  localparam logic [ExpW-1:0] EXP_UNKNOWN     = 2'd3;
  localparam logic [1:0]      REG_UNUSED      = 2'd3;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [ApbW-1:0]  pwdata;
  logic [ApbW-1:0]  prdata;
  logic             pready;
  int               read_errors;
  int               reads_pending;
  int               burst_left;
  int               items_sent;
  int               idle_cycles;

  cpsr_req_if req_if ();
  cpsr_rsp_if rsp_if ();

  controller_port_serial_reader_unit u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req_i   (req_if),
    .rsp_o   (rsp_if)
  );

  port_read_monitor u_monitor (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req       (req_if),
    .rsp       (rsp_if),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .errors_o  (read_errors),
    .pending_o (reads_pending)
  );

  always #5 clk_i = ~clk_i;

  function automatic logic [BtnW-1:0] rand_buttons();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return BtnW'($urandom);
    endcase
  endfunction

  function automatic req_t noise_req();
    req_t r;
    r.req_type          = 1'($urandom);
    r.latch_value       = 1'($urandom);
    r.port              = 1'($urandom);
    r.port_buttons      = rand_buttons();
    r.port_trigger      = 1'($urandom);
    r.expansion_buttons = rand_buttons();
    r.expansion_trigger = 1'($urandom);
    return r;
  endfunction

  function automatic req_t latch_req(input logic v);
    req_t r;
    r = noise_req();
    r.req_type    = REQ_LATCH;
    r.latch_value = v;
    return r;
  endfunction

  function automatic req_t rand_read(input logic p);
    req_t r;
    r = noise_req();
    r.req_type = REQ_READ;
    r.port     = p;
    return r;
  endfunction

  function automatic req_t read_req(input logic p, input logic [BtnW-1:0] btn,
                                    input logic [BtnW-1:0] xbtn, input logic trig,
                                    input logic xtrig);
    req_t r;
    r = rand_read(p);
    r.port_buttons      = btn;
    r.expansion_buttons = xbtn;
    r.port_trigger      = trig;
    r.expansion_trigger = xtrig;
    return r;
  endfunction

  task automatic send_req(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk_i);
        req_if.valid = 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
    burst_left--;
    @(negedge clk_i);
    req_if.req_type          = r.req_type;
    req_if.latch_value       = r.latch_value;
    req_if.port              = r.port;
    req_if.port_buttons      = r.port_buttons;
    req_if.port_trigger      = r.port_trigger;
    req_if.expansion_buttons = r.expansion_buttons;
    req_if.expansion_trigger = r.expansion_trigger;
    req_if.valid             = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    items_sent++;
  endtask

  // Stop sending and wait until every read result has come back and the
  // request pipeline has drained.
  task automatic settle();
    @(negedge clk_i);
    req_if.valid = 1'b0;
    burst_left   = 0;
    while (reads_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic apb_write(input logic [1:0] idx, input logic [ApbW-1:0] data);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = data;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic configure(input logic [DevW-1:0] d0, input logic [DevW-1:0] d1,
                           input logic [ExpW-1:0] dx);
    settle();
    apb_write(REG_PORT0, ApbW'(d0));
    apb_write(REG_PORT1, ApbW'(d1));
    apb_write(REG_EXPANSION, ApbW'(dx));
  endtask

  // Mostly strobe pulses followed by runs of reads long enough to reach the
  // counter limit, with random requests mixed in.
  task automatic random_traffic(input int n_items);
    int   stop_at;
    int   run_len;
    logic fixed_port;
    logic p;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 6) == 0) begin
        send_req(noise_req());
      end else begin
        send_req(latch_req(1'b1));
        repeat ($urandom_range(0, 2)) send_req(rand_read(1'($urandom)));
        send_req(latch_req(1'b0));
        run_len    = $urandom_range(1, 40);
        fixed_port = 1'($urandom);
        p          = 1'($urandom);
        repeat (run_len) send_req(rand_read(fixed_port ? p : 1'($urandom)));
      end
    end
  endtask

  initial begin
    int mode;
    int left;
    rsp_if.ready = 1'b0;
    mode = 0;
    left = 0;
    forever begin
      @(negedge clk_i);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(8, 80);
      end
      left--;
      case (mode)
        0:       rsp_if.ready = 1'b1;
        1:       rsp_if.ready = 1'($urandom);
        2:       rsp_if.ready = ($urandom_range(0, 3) == 0);
        default: rsp_if.ready = left[2];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [DevW-1:0] d0;
    logic [DevW-1:0] d1;
    logic [ExpW-1:0] dx;
    idle_cycles = 0;
    burst_left  = 0;
    items_sent  = 0;
    rst_ni      = 1'b0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    req_if.valid             = 1'b0;
    req_if.req_type          = REQ_LATCH;
    req_if.latch_value       = 1'b0;
    req_if.port              = 1'b0;
    req_if.port_buttons      = '0;
    req_if.port_trigger      = 1'b0;
    req_if.expansion_buttons = '0;
    req_if.expansion_trigger = 1'b0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Joypads with four-player pads: reads under strobe, then past the eighth bit.
    send_req(latch_req(1'b1));
    send_req(read_req(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_req(read_req(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b0));
    send_req(latch_req(1'b0));
    for (int i = 0; i < 9; i++) begin
      send_req(read_req(1'b0, i[0] ? 16'h0000 : 16'hFFFF, i[0] ? 16'hFFFF : 16'h0000,
                        1'b0, 1'b0));
    end
    send_req(read_req(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));

    // Mat pad, light gun and beam gun; a write to the unused address is ignored.
    configure(DEV_MATPAD, DEV_LIGHTGUN, EXP_BEAMGUN);
    apb_write(REG_UNUSED, ApbW'(DEV_NONE));
    send_req(latch_req(1'b1));
    send_req(latch_req(1'b0));
    for (int i = 0; i < 5; i++) begin
      send_req(read_req(1'b0, i[0] ? 16'h0000 : 16'hFFFF, 16'h0000, 1'b0, 1'b0));
    end
    send_req(read_req(1'b1, 16'h0000, 16'h0000, 1'b1, 1'b0));
    send_req(read_req(1'b1, 16'h0000, 16'h0000, 1'b0, 1'b1));

    // An empty port, an unknown port device and an unknown expansion device.
    configure(DEV_NONE, DEV_UNKNOWN, EXP_UNKNOWN);
    send_req(read_req(1'b0, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    send_req(read_req(1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1));

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin d0 = DEV_NONE;      d1 = DEV_NONE;      dx = EXP_NONE;       end
        1: begin d0 = DEV_MATPAD;    d1 = DEV_MATPAD;    dx = EXP_BEAMGUN;    end
        2: begin d0 = DEV_UNKNOWN;   d1 = DEV_UNKNOWN;   dx = EXP_UNKNOWN;    end
        3: begin d0 = DEV_FOURSCORE; d1 = DEV_FOURSCORE; dx = EXP_FOURPLAYER; end
        4: begin d0 = DEV_LIGHTGUN;  d1 = DEV_MATPAD;    dx = EXP_BEAMGUN;    end
        5: begin d0 = DEV_FOURSCORE; d1 = DEV_JOYPAD;    dx = EXP_NONE;       end
        default: begin
          d0 = ($urandom_range(0, 4) == 0) ? DevW'($urandom_range(5, 7))
                                           : DevW'($urandom_range(0, 4));
          d1 = ($urandom_range(0, 4) == 0) ? DevW'($urandom_range(5, 7))
                                           : DevW'($urandom_range(0, 4));
          dx = ExpW'($urandom_range(0, 3));
        end
      endcase
      configure(d0, d1, dx);
      random_traffic(ITEMS_PER_PHASE);
    end

    settle();
    if (read_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
